// ===== design/rzs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling z-score signal package
// Shared widths, constants, types and state codes for the signal block.
// ----------------------------------------------------------------------------
package rzs_pkg;

	localparam int WINDOW_LEN  = 64;
	localparam int WIN_BITS    = $clog2(WINDOW_LEN);
	localparam int CNT_BITS    = WIN_BITS + 1;
	localparam int SYM_COUNT   = 16;
	localparam int SYM_BITS    = 4;
	localparam int PRICE_BITS  = 24;
	localparam int MID_BITS    = PRICE_BITS + 1;
	localparam int MSQ_BITS    = 2 * MID_BITS;
	localparam int SUM_BITS    = MID_BITS + WIN_BITS;
	localparam int SQ_BITS     = MSQ_BITS + WIN_BITS;
	localparam int NQ_BITS     = SQ_BITS + WIN_BITS;
	localparam int SS_BITS     = 2 * SUM_BITS;
	localparam int VAR_BITS    = (NQ_BITS > SS_BITS) ? NQ_BITS : SS_BITS;
	localparam int THR_BITS    = 8;
	localparam int QTY_BITS    = 32;
	localparam int POS_BITS    = 32;
	localparam int DSQ_BITS    = 2 * SUM_BITS + 4;
	localparam int CMP_BITS    = VAR_BITS + THR_BITS;
	localparam int RING_DEPTH  = SYM_COUNT * WINDOW_LEN;
	localparam int RING_ABITS  = SYM_BITS + WIN_BITS;
	localparam int CFG_IBITS   = 2;

	localparam logic [CFG_IBITS-1:0] CFG_ENTRY = CFG_IBITS'(0);
	localparam logic [CFG_IBITS-1:0] CFG_EXIT  = CFG_IBITS'(1);
	localparam logic [THR_BITS-1:0]  ENTRY_RESET = THR_BITS'(64);
	localparam logic [THR_BITS-1:0]  EXIT_RESET  = THR_BITS'(4);

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_FILL = 1'b1;
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic signed [POS_BITS-1:0] pos;
		logic [SQ_BITS-1:0]         sq;
		logic [SUM_BITS-1:0]        sum;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_DEV,
		ST_MUL,
		ST_VAR,
		ST_THR
	} state_t;

endpackage

// ===== design/rzs_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-symbol statistics store
// Synchronous memory for window sum, sum of squares and position, with one
// valid bit per symbol so that an entry reads as zero until first written.
// ----------------------------------------------------------------------------
module rzs_stats
	import rzs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SYM_BITS-1:0] rd_addr,
	output stat_t               rd_data,
	input  logic                wr_en,
	input  logic [SYM_BITS-1:0] wr_addr,
	input  stat_t               wr_data
);

	stat_t                mem [SYM_COUNT];
	logic [SYM_COUNT-1:0] valid_q;
	stat_t                rd_raw_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// An entry never written holds the reset value of zero.
	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

// ===== design/rolling_zscore_signal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling z-score mean-reversion signal
// Per-symbol rolling window of mids with exact integer z-score test.
// ----------------------------------------------------------------------------
// A market tick transaction whose window is full after its update passes, from
// its acceptance to the acceptance of the next transaction, through the
// memory read, the window update, the deviation, the two squares, the variance,
// the threshold test and the return to idle. A tick that leaves its window short
// of full ends after the update. A fill transaction ends after the read.
// The sequence is set by the read-modify-write of the per-symbol statistics
// memory and the mid ring memory (each with a registered read), followed by the
// chain of adds, two squaring multipliers and the threshold multiply that
// decide the order. One transaction is in flight at a time; a finished order
// waits in the output register while the next transaction is taken. A test
// that finds an order stays in the threshold stage for as long as the previous
// order is still held in the output register by a stall. No
// clearing pass runs after reset: the statistics store uses valid bits and
// the ring output is only used once every slot of that symbol has been written.
// Thresholds are written through the configuration port while idle; the block itself does not enforce this.
module rolling_zscore_signal
	import rzs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IBITS-1:0]  cfg_index,
	input  logic [THR_BITS-1:0]   cfg_data,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  logic                  mode,
	input  logic [SYM_BITS-1:0]   symbol,
	input  logic [PRICE_BITS-1:0] bid_price,
	input  logic [PRICE_BITS-1:0] ask_price,
	input  logic                  fill_side,
	input  logic [QTY_BITS-1:0]   fill_amount,
	output logic                  order_valid,
	input  logic                  order_stall,
	output logic                  order_side,
	output logic [SYM_BITS-1:0]   order_symbol,
	output logic [PRICE_BITS-1:0] order_price,
	output logic [QTY_BITS-1:0]   order_qty
);

	state_t state_q, state_d;

	logic [THR_BITS-1:0] entry_q, exit_q;

	// Captured transaction.
	logic                  mode_q;
	logic [SYM_BITS-1:0]   sym_q;
	logic [PRICE_BITS-1:0] bid_q, ask_q;
	logic                  side_q;
	logic [QTY_BITS-1:0]   qty_q;
	logic [MID_BITS-1:0]   mid_q;

	// Fill counts and ring heads are small per-symbol registers.
	logic [CNT_BITS-1:0] count_q [SYM_COUNT];
	logic [WIN_BITS-1:0] head_q  [SYM_COUNT];

	logic accept;
	logic stats_we;
	stat_t stats_rd, stats_wd;

	// Mid ring memory, addressed by symbol and slot.
	logic [MID_BITS-1:0]   ring_mem [RING_DEPTH];
	logic [MID_BITS-1:0]   ring_rd_q;
	logic                  ring_we;
	logic [RING_ABITS-1:0] ring_raddr, ring_waddr;

	// Datapath stages.
	stat_t               stat_s2;
	logic [MID_BITS-1:0] old_s2;
	logic [MSQ_BITS-1:0] old_sq_s2, mid_sq_s2;
	logic                full_s2;
	logic [SUM_BITS-1:0] sum_s3;
	logic [SQ_BITS-1:0]  sq_s3;
	logic                eval_s3;
	logic [SUM_BITS-1:0] mag_s4;
	logic                devnn_s4;
	logic [SS_BITS-1:0]  ss_s5;
	logic [DSQ_BITS-1:0] dsq_s5;
	logic [VAR_BITS-1:0] var_s6;
	logic                varpos_s6;

	logic [SUM_BITS-1:0] sum_new;
	logic [SQ_BITS-1:0]  sq_new;
	logic [CNT_BITS-1:0] cnt_cur;
	logic [SUM_BITS-1:0] nm;
	logic [NQ_BITS-1:0]  nq;
	logic [THR_BITS-1:0] thr;
	logic [CMP_BITS-1:0] prod;
	logic                hit, flat, result, out_free, fire;
	logic signed [POS_BITS+1:0] pos_sum;
	logic signed [POS_BITS-1:0] pos_new;

	assign accept   = tick_valid && !tick_stall;
	assign out_free = !order_valid || !order_stall;
	assign cnt_cur  = count_q[sym_q];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= ENTRY_RESET;
			exit_q  <= EXIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENTRY: entry_q <= cfg_data;
				CFG_EXIT:  exit_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_RD;
			ST_RD:   state_d = (mode_q == MODE_FILL) ? ST_IDLE : ST_UPD;
			ST_UPD:  state_d = ((cnt_cur == CNT_BITS'(WINDOW_LEN)) ||
			                    (cnt_cur == CNT_BITS'(WINDOW_LEN - 1))) ? ST_DEV : ST_IDLE;
			ST_DEV:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_VAR;
			ST_VAR:  state_d = ST_THR;
			ST_THR:  if (out_free || !result) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		tick_stall = (state_q != ST_IDLE);
		stats_we   = 1'b0;
		ring_we    = 1'b0;
		fire       = 1'b0;
		case (state_q)
			ST_RD:   stats_we = (mode_q == MODE_FILL);
			ST_UPD: begin
				stats_we = 1'b1;
				ring_we  = 1'b1;
			end
			ST_THR:  fire = out_free && result;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture of the accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			sym_q  <= symbol;
			bid_q  <= bid_price;
			ask_q  <= ask_price;
			side_q <= fill_side;
			qty_q  <= fill_amount;
			mid_q  <= MID_BITS'(bid_price) + MID_BITS'(ask_price);
		end
	end

	rzs_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (symbol),
		.rd_data (stats_rd),
		.wr_en   (stats_we),
		.wr_addr (sym_q),
		.wr_data (stats_wd)
	);

	assign ring_raddr = {symbol, head_q[symbol]};
	assign ring_waddr = {sym_q, head_q[sym_q]};

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= mid_q;
		end
		ring_rd_q <= ring_mem[ring_raddr];
	end

	// Fill: add or subtract the quantity and clamp to the 32-bit range.
	always_comb begin
		if (side_q == SIDE_SELL) begin
			pos_sum = (POS_BITS+2)'(stats_rd.pos) - $signed({2'b00, qty_q});
		end else begin
			pos_sum = (POS_BITS+2)'(stats_rd.pos) + $signed({2'b00, qty_q});
		end
		if (pos_sum > $signed((POS_BITS+2)'({1'b0, {(POS_BITS-1){1'b1}}}))) begin
			pos_new = {1'b0, {(POS_BITS-1){1'b1}}};
		end else if (pos_sum < -$signed((POS_BITS+2)'({1'b1, {(POS_BITS-1){1'b0}}}))) begin
			pos_new = {1'b1, {(POS_BITS-1){1'b0}}};
		end else begin
			pos_new = pos_sum[POS_BITS-1:0];
		end
	end

	// Window update: the oldest mid leaves once the window is full.
	always_comb begin
		if (full_s2) begin
			sum_new = stat_s2.sum + SUM_BITS'(mid_q) - SUM_BITS'(old_s2);
			sq_new  = stat_s2.sq + SQ_BITS'(mid_sq_s2) - SQ_BITS'(old_sq_s2);
		end else begin
			sum_new = stat_s2.sum + SUM_BITS'(mid_q);
			sq_new  = stat_s2.sq + SQ_BITS'(mid_sq_s2);
		end
	end

	always_comb begin
		stats_wd = '{pos: stat_s2.pos, sq: sq_new, sum: sum_new};
		if (state_q == ST_RD) begin
			stats_wd = '{pos: pos_new, sq: stats_rd.sq, sum: stats_rd.sum};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYM_COUNT; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
			end
		end else if (state_q == ST_UPD) begin
			head_q[sym_q] <= head_q[sym_q] + WIN_BITS'(1);
			if (!full_s2) begin
				count_q[sym_q] <= cnt_cur + CNT_BITS'(1);
			end
		end
	end

	assign nm = SUM_BITS'(mid_q) << WIN_BITS;
	assign nq = NQ_BITS'(sq_s3) << WIN_BITS;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD: begin
				stat_s2   <= stats_rd;
				old_s2    <= ring_rd_q;
				old_sq_s2 <= MSQ_BITS'(ring_rd_q) * MSQ_BITS'(ring_rd_q);
				mid_sq_s2 <= MSQ_BITS'(mid_q) * MSQ_BITS'(mid_q);
				full_s2   <= (cnt_cur == CNT_BITS'(WINDOW_LEN));
			end
			ST_UPD: begin
				sum_s3  <= sum_new;
				sq_s3   <= sq_new;
				eval_s3 <= 1'b1;
			end
			ST_DEV: begin
				devnn_s4 <= (nm >= sum_s3);
				mag_s4   <= (nm >= sum_s3) ? (nm - sum_s3) : (sum_s3 - nm);
			end
			ST_MUL: begin
				ss_s5  <= SS_BITS'(sum_s3) * SS_BITS'(sum_s3);
				dsq_s5 <= DSQ_BITS'(SS_BITS'(mag_s4) * SS_BITS'(mag_s4)) << 4;
			end
			ST_VAR: begin
				varpos_s6 <= (VAR_BITS'(nq) > VAR_BITS'(ss_s5));
				var_s6    <= VAR_BITS'(nq) - VAR_BITS'(ss_s5);
			end
			default: eval_s3 <= 1'b0;
		endcase
	end

	// Threshold test: flat looks for entry, holding looks for exit.
	always_comb begin
		flat   = (stat_s2.pos == '0);
		thr    = flat ? entry_q : exit_q;
		prod   = CMP_BITS'(var_s6) * CMP_BITS'(thr);
		hit    = flat ? (CMP_BITS'(dsq_s5) >= prod) : (CMP_BITS'(dsq_s5) <= prod);
		result = varpos_s6 && hit;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_valid <= 1'b0;
		end else if (fire) begin
			order_valid <= 1'b1;
		end else if (!order_stall) begin
			order_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			order_symbol <= sym_q;
			if (flat) begin
				order_side  <= devnn_s4 ? SIDE_SELL : SIDE_BUY;
				order_price <= devnn_s4 ? bid_q : ask_q;
				order_qty   <= QTY_BITS'(1);
			end else begin
				order_side  <= (stat_s2.pos > 0) ? SIDE_SELL : SIDE_BUY;
				order_price <= (stat_s2.pos > 0) ? bid_q : ask_q;
				order_qty   <= (stat_s2.pos > 0) ? QTY_BITS'(stat_s2.pos)
				                                 : QTY_BITS'(-stat_s2.pos);
			end
		end
	end

	// A new order only ever comes out of the threshold stage.
	a_order_from_thr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(order_valid) |-> $past(state_q == ST_THR))
		else $error("order raised outside the threshold stage");

	// An accepted transaction always goes to the memory read stage.
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RD)
		else $error("accepted transaction did not start a read");

	// Evaluation follows only a window update of a tick.
	a_eval_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DEV |-> eval_s3 && mode_q == MODE_TICK)
		else $error("evaluation without a tick update");

	// The fill count never passes the window length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> cnt_cur <= CNT_BITS'(WINDOW_LEN))
		else $error("fill count beyond window length");

	// A fill never leaves the read stage for the update stage.
	a_fill_short: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD && mode_q == MODE_FILL |=> state_q == ST_IDLE)
		else $error("fill transaction continued past the read stage");

endmodule
